/* sv/sdwv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdwv_pkg;

   // store geometry
   localparam int DEPTH  = 4096;
   localparam int ADDR_W = $clog2(DEPTH);

   // item modes
   localparam logic [1:0] MODE_DOT   = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_SET   = 2'd2;
   localparam logic [1:0] MODE_SCALE = 2'd3;

   // fixed point limits
   localparam logic [47:0] ONE_SCALE = 48'h0001_0000_0000;
   localparam logic [47:0] SCALE_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [62:0] NORM_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [40:0] DIV_CAP   = 41'h100_0000_0000;

   // sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_MUL, ST_DIV,
      ST_DOT1, ST_DOT2, ST_ADD1, ST_ADD2, ST_SET2,
      ST_NO1, ST_NO2, ST_NN1, ST_NN2,
      ST_SC2, ST_SC3, ST_SC4,
      ST_FRD, ST_FLD, ST_FWR, ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* sv/scaled_dense_weight_vector_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A result reaches rsp_valid after the item marked req_last. A scale item sweeps
// every store entry when the scale folds into the weights.
// One item at a time: busy is high from accept until the item has finished.
// The rate is set by the 32x32 partial product multiplier and the radix-2
// divider; the single RAM port serializes the fold sweep.
// Synchronous reset starts a clear of the whole store, busy stays high until it ends.
// A result is shown for one cycle; the receiver cannot stall it.

module scaled_dense_weight_vector_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [11:0]        req_index,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_coef,
   input  wire logic               req_last,
   output logic                    rsp_valid,
   output logic signed [63:0]      rsp_dot_sum,
   output logic [62:0]             rsp_squared_norm,
   output logic                    rsp_index_error,
   input  wire logic               csr_we,
   input  wire logic [31:0]        csr_wdata
);
   import sdwv_pkg::*;

   function automatic logic [31:0] magn32(input logic [31:0] x);
      return x[31] ? 32'(32'd0 - x) : x;
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [42:0] x);
      if (x > 43'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -43'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   // control state
   state_type          state_ff, state_in, mul_ret_ff, mul_ret_in, div_ret_ff, div_ret_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]        floor_ff, floor_in;
   logic [47:0]        scale_ff, scale_in;
   logic [62:0]        norm_ff, norm_in;
   logic [63:0]        acc_ff, acc_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         mul_step_ff, mul_step_in;
   logic [6:0]         div_cnt_ff, div_cnt_in;

   // payload state
   logic [1:0]         mode_ff, mode_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [31:0]        v_ff, v_in, c_ff, c_in, w_ff, w_in, nw_ff, nw_in;
   logic               last_ff, last_in;
   logic [63:0]        mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [127:0]       prod_ff, prod_in;
   logic [95:0]        div_dv_ff, div_dv_in;
   logic [47:0]        div_rem_ff, div_rem_in;
   logic [39:0]        div_q_ff, div_q_in;
   logic               div_cap_ff, div_cap_in;
   logic [63:0]        rsp_dot_ff, rsp_dot_in;
   logic [62:0]        rsp_norm_ff, rsp_norm_in;
   logic               rsp_err_ff, rsp_err_in;

   // memory port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [31:0]        ram_wdata, ram_rdata;

   // call requests
   logic               mul_go, div_go;
   logic [63:0]        mul_a, mul_b;
   logic [95:0]        div_num;
   state_type          mul_ret, div_ret;

   // datapath temporaries
   logic [31:0]        pp_x, pp_y;
   logic [63:0]        pp;
   logic [6:0]         pp_sh;
   logic [48:0]        rem_sh;
   logic               rem_ge;
   logic [40:0]        q_next, div_d, fold_m;
   logic               neg, over;
   logic [63:0]        dot_m, dot_t;
   logic signed [64:0] dot_sum65;
   logic [62:0]        sq;
   logic [63:0]        norm_sum64;
   logic [47:0]        new_scale;
   logic signed [42:0] wsum;
   logic               idx_ok;

   sdwv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // shared 32x32 partial product, one per cycle
   assign pp_x  = mul_step_ff[1] ? mul_a_ff[63:32] : mul_a_ff[31:0];
   assign pp_y  = mul_step_ff[0] ? mul_b_ff[63:32] : mul_b_ff[31:0];
   assign pp    = 64'(pp_x) * 64'(pp_y);
   assign pp_sh = {2'({1'b0, mul_step_ff[1]}) + 2'({1'b0, mul_step_ff[0]}), 5'd0};

   // restoring divider step against the scale
   assign rem_sh = {div_rem_ff, div_dv_ff[95]};
   assign rem_ge = rem_sh >= {1'b0, scale_ff};
   assign q_next = {div_q_ff, rem_ge};
   assign div_d  = div_cap_ff ? DIV_CAP : {1'b0, div_q_ff};

   assign sq     = (prod_ff[127:63] != '0) ? NORM_MAX : prod_ff[62:0];
   assign idx_ok = 32'(req_index) < 32'(DEPTH);

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dot_sum      = rsp_dot_ff;
   assign rsp_squared_norm = rsp_norm_ff;
   assign rsp_index_error  = rsp_err_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mul_ret_in   = mul_ret_ff;
      div_ret_in   = div_ret_ff;
      cnt_in       = cnt_ff;
      floor_in     = csr_we ? csr_wdata : floor_ff;
      scale_in     = scale_ff;
      norm_in      = norm_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      rsp_valid_in = 1'b0;
      mul_step_in  = mul_step_ff;
      div_cnt_in   = div_cnt_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      v_in         = v_ff;
      c_in         = c_ff;
      w_in         = w_ff;
      nw_in        = nw_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      prod_in      = prod_ff;
      div_dv_in    = div_dv_ff;
      div_rem_in   = div_rem_ff;
      div_q_in     = div_q_ff;
      div_cap_in   = div_cap_ff;
      rsp_dot_in   = rsp_dot_ff;
      rsp_norm_in  = rsp_norm_ff;
      rsp_err_in   = rsp_err_ff;
      ram_we       = 1'b0;
      ram_addr     = cnt_ff;
      ram_wdata    = '0;
      mul_go       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      mul_ret      = ST_IDLE;
      div_go       = 1'b0;
      div_num      = '0;
      div_ret      = ST_IDLE;
      neg          = 1'b0;
      over         = 1'b0;
      dot_m        = '0;
      dot_t        = '0;
      dot_sum65    = '0;
      norm_sum64   = '0;
      new_scale    = '0;
      wsum         = '0;
      fold_m       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_addr = ADDR_W'(req_index);
            if (start) begin
               mode_in = req_mode;
               addr_in = ADDR_W'(req_index);
               v_in    = req_value;
               c_in    = req_coef;
               if (req_mode == MODE_SCALE) begin
                  mul_go  = 1'b1;
                  mul_a   = {32'd0, magn32(req_coef)};
                  mul_b   = {32'd0, magn32(req_coef)};
                  mul_ret = ST_SC2;
               end else if (!idx_ok) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            w_in = ram_rdata;
            if (mode_ff == MODE_DOT) begin
               mul_go  = 1'b1;
               mul_a   = {32'd0, magn32(ram_rdata)};
               mul_b   = {16'd0, scale_ff};
               mul_ret = ST_DOT1;
            end else if (mode_ff == MODE_ADD) begin
               mul_go  = 1'b1;
               mul_a   = {32'd0, magn32(c_ff)};
               mul_b   = {32'd0, magn32(v_ff)};
               mul_ret = ST_ADD1;
            end else begin
               div_go  = 1'b1;
               div_num = {32'd0, magn32(v_ff), 32'd0};
               div_ret = ST_SET2;
            end
         end
         ST_MUL: begin
            prod_in     = prod_ff + (128'(pp) << pp_sh);
            mul_step_in = mul_step_ff + 1'b1;
            if (mul_step_ff == 2'd3) begin
               state_in = mul_ret_ff;
            end
         end
         ST_DIV: begin
            div_rem_in = rem_ge ? 48'(rem_sh - {1'b0, scale_ff}) : rem_sh[47:0];
            div_q_in   = q_next[39:0];
            div_cap_in = div_cap_ff | q_next[40];
            div_dv_in  = {div_dv_ff[94:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 7'd95) begin
               state_in = div_ret_ff;
            end
         end
         ST_DOT1: begin
            mul_go  = 1'b1;
            mul_a   = prod_ff[95:32];
            mul_b   = {32'd0, magn32(v_ff)};
            mul_ret = ST_DOT2;
         end
         ST_DOT2: begin
            // saturating signed term, then saturating accumulate
            neg   = w_ff[31] ^ v_ff[31];
            dot_m = neg ? 64'h8000_0000_0000_0000 : {1'b0, NORM_MAX};
            over  = (prod_ff[127:64] != '0) || (prod_ff[63:0] > dot_m);
            if (!over) begin
               dot_m = prod_ff[63:0];
            end
            dot_t     = neg ? 64'(64'd0 - dot_m) : dot_m;
            dot_sum65 = $signed({acc_ff[63], acc_ff}) + $signed({dot_t[63], dot_t});
            if (dot_sum65 > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
               acc_in = 64'h7FFF_FFFF_FFFF_FFFF;
            end else if (dot_sum65 < -65'sh0_8000_0000_0000_0000) begin
               acc_in = 64'h8000_0000_0000_0000;
            end else begin
               acc_in = dot_sum65[63:0];
            end
            state_in = ST_DONE;
         end
         ST_ADD1: begin
            div_go  = 1'b1;
            div_num = {24'd0, prod_ff[63:0], 8'd0};
            div_ret = ST_ADD2;
         end
         ST_ADD2: begin
            neg   = c_ff[31] ^ v_ff[31];
            wsum  = $signed({{11{w_ff[31]}}, w_ff})
                  + (neg ? $signed(43'(43'd0 - {2'd0, div_d})) : $signed({2'd0, div_d}));
            nw_in   = clamp32(wsum);
            mul_go  = 1'b1;
            mul_a   = {32'd0, magn32(w_ff)};
            mul_b   = {16'd0, scale_ff};
            mul_ret = ST_NO1;
         end
         ST_SET2: begin
            wsum    = v_ff[31] ? $signed(43'(43'd0 - {2'd0, div_d})) : $signed({2'd0, div_d});
            nw_in   = clamp32(wsum);
            mul_go  = 1'b1;
            mul_a   = {32'd0, magn32(w_ff)};
            mul_b   = {16'd0, scale_ff};
            mul_ret = ST_NO1;
         end
         ST_NO1: begin
            mul_go  = 1'b1;
            mul_a   = prod_ff[95:32];
            mul_b   = prod_ff[95:32];
            mul_ret = ST_NO2;
         end
         ST_NO2: begin
            // take out the old weight's share, store the new weight
            norm_in   = (norm_ff > sq) ? 63'(norm_ff - sq) : '0;
            ram_we    = 1'b1;
            ram_addr  = addr_ff;
            ram_wdata = nw_ff;
            mul_go    = 1'b1;
            if (mode_ff == MODE_ADD) begin
               mul_a   = {32'd0, magn32(nw_ff)};
               mul_b   = {16'd0, scale_ff};
               mul_ret = ST_NN1;
            end else begin
               mul_a   = {32'd0, magn32(v_ff)};
               mul_b   = {32'd0, magn32(v_ff)};
               mul_ret = ST_NN2;
            end
         end
         ST_NN1: begin
            mul_go  = 1'b1;
            mul_a   = prod_ff[95:32];
            mul_b   = prod_ff[95:32];
            mul_ret = ST_NN2;
         end
         ST_NN2: begin
            norm_sum64 = {1'b0, norm_ff} + {1'b0, sq};
            norm_in    = norm_sum64[63] ? NORM_MAX : norm_sum64[62:0];
            state_in   = ST_DONE;
         end
         ST_SC2: begin
            mul_go  = 1'b1;
            mul_a   = {1'b0, norm_ff};
            mul_b   = prod_ff[63:0];
            mul_ret = ST_SC3;
         end
         ST_SC3: begin
            norm_in = (prod_ff[127:111] != '0) ? NORM_MAX : prod_ff[110:48];
            mul_go  = 1'b1;
            mul_a   = {16'd0, scale_ff};
            mul_b   = {32'd0, magn32(c_ff)};
            mul_ret = ST_SC4;
         end
         ST_SC4: begin
            new_scale = (prod_ff[127:72] != '0) ? SCALE_MAX : prod_ff[71:24];
            scale_in  = new_scale;
            if (c_ff[31] || (new_scale == '0) || (new_scale < {16'd0, floor_ff})) begin
               cnt_in   = '0;
               state_in = ST_FRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FRD: begin
            state_in = ST_FLD;
         end
         ST_FLD: begin
            w_in    = ram_rdata;
            mul_go  = 1'b1;
            mul_a   = {32'd0, magn32(ram_rdata)};
            mul_b   = {16'd0, scale_ff};
            mul_ret = ST_FWR;
         end
         ST_FWR: begin
            // fold the signed scale into this weight
            over      = (prod_ff[127:73] != '0) || (prod_ff[72] && (prod_ff[71:32] != '0));
            fold_m    = over ? DIV_CAP : prod_ff[72:32];
            neg       = w_ff[31] ^ c_ff[31];
            wsum      = neg ? $signed(43'(43'd0 - {2'd0, fold_m})) : $signed({2'd0, fold_m});
            ram_we    = 1'b1;
            ram_wdata = clamp32(wsum);
            if (cnt_ff == ADDR_W'(DEPTH - 1)) begin
               scale_in = ONE_SCALE;
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_FRD;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // emit on the closing element of a vector
      if (state_ff == ST_DONE && last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_dot_in   = acc_ff;
         rsp_norm_in  = norm_ff;
         rsp_err_in   = err_ff;
         acc_in       = '0;
         err_in       = 1'b0;
      end

      // multiplier call
      if (mul_go) begin
         mul_a_in    = mul_a;
         mul_b_in    = mul_b;
         mul_ret_in  = mul_ret;
         mul_step_in = '0;
         prod_in     = '0;
         state_in    = ST_MUL;
      end

      // divider call
      if (div_go) begin
         div_dv_in  = div_num;
         div_rem_in = '0;
         div_q_in   = '0;
         div_cap_in = 1'b0;
         div_cnt_in = '0;
         div_ret_in = div_ret;
         state_in   = ST_DIV;
      end
   end

   assign last_in = (state_ff == ST_IDLE && start) ? req_last : last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mul_ret_ff   <= ST_IDLE;
         div_ret_ff   <= ST_IDLE;
         cnt_ff       <= '0;
         floor_ff     <= 32'd1;
         scale_ff     <= ONE_SCALE;
         norm_ff      <= '0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_step_ff  <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         mul_ret_ff   <= mul_ret_in;
         div_ret_ff   <= div_ret_in;
         cnt_ff       <= cnt_in;
         floor_ff     <= floor_in;
         scale_ff     <= scale_in;
         norm_ff      <= norm_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_step_ff  <= mul_step_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      v_ff        <= v_in;
      c_ff        <= c_in;
      w_ff        <= w_in;
      nw_ff       <= nw_in;
      last_ff     <= last_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= prod_in;
      div_dv_ff   <= div_dv_in;
      div_rem_ff  <= div_rem_in;
      div_q_ff    <= div_q_in;
      div_cap_ff  <= div_cap_in;
      rsp_dot_ff  <= rsp_dot_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_err_ff  <= rsp_err_in;
   end

endmodule

`default_nettype wire

/* sv/sdwv_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdwv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import sdwv_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 286;

   // one result of a closed sparse vector
   typedef struct {
      logic signed [63:0] dot;
      logic [62:0]        nrm;
      logic               ierr;
   } vec_result_type;

   // weight store mirror, predicts the result of each closed vector
   class weight_scoreboard;
      logic signed [31:0] weights [DEPTH];
      logic [47:0]        scale;
      logic [63:0]        norm;
      logic signed [63:0] acc;
      bit                 err_seen;
      logic [31:0]        floor_q;
      vec_result_type     pending [$];
      int                 errors;

      function new();
         foreach (weights[i]) weights[i] = '0;
         scale    = ONE_SCALE;
         norm     = '0;
         acc      = '0;
         err_seen = 0;
         floor_q  = 32'd1;
         errors   = 0;
      endfunction

      function logic [63:0] mag(logic signed [63:0] x);
         return x[63] ? -x : x;
      endfunction

      // magnitude of the scaled weight
      function logic [63:0] eff_mag(logic signed [31:0] w);
         logic [127:0] p;
         p = mag(w) * scale;
         return p[95:32];
      endfunction

      function logic [63:0] square_sat(logic [63:0] m);
         logic [127:0] p;
         p = m * m;
         return (p > NORM_MAX) ? {1'b0, NORM_MAX} : p[63:0];
      endfunction

      // floor(num / d) capped at DIV_CAP
      function logic signed [63:0] div_capped(logic [127:0] num, logic [47:0] d);
         logic [127:0] q;
         q = num / d;
         return (q >= DIV_CAP) ? 64'(DIV_CAP) : 64'(q[40:0]);
      endfunction

      function logic signed [31:0] clamp32(logic signed [63:0] x);
         if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
         if (x < -64'sh8000_0000) return 32'sh8000_0000;
         return x[31:0];
      endfunction

      function void norm_sub(logic [63:0] x);
         norm = (norm > x) ? norm - x : '0;
      endfunction

      function void norm_add(logic [63:0] x);
         norm = (x > NORM_MAX - norm) ? {1'b0, NORM_MAX} : norm + x;
      endfunction

      function void dot_step(logic signed [31:0] w, logic signed [63:0] v);
         bit                 neg;
         logic [127:0]       p;
         logic [63:0]        cap;
         logic [63:0]        m;
         logic signed [63:0] t;
         logic signed [64:0] s65;
         neg = w[31] ^ v[63];
         p   = eff_mag(w) * mag(v);
         cap = neg ? 64'h8000_0000_0000_0000 : {1'b0, NORM_MAX};
         m   = (p > cap) ? cap : p[63:0];
         t   = neg ? -m : m;
         s65 = acc + t;
         if (s65 > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
         else if (s65 < -65'sh0_8000_0000_0000_0000) acc = 64'sh8000_0000_0000_0000;
         else acc = s65[63:0];
      endfunction

      function void scale_step(logic signed [63:0] c);
         logic [63:0]        cm;
         logic [127:0]       p;
         logic [127:0]       sh;
         logic [47:0]        s;
         logic [63:0]        m;
         logic signed [63:0] mw;
         cm = mag(c);
         p  = scale * cm;
         sh = p >> 24;
         s  = (sh > SCALE_MAX) ? SCALE_MAX : sh[47:0];
         p  = norm * (cm * cm);
         sh = p >> 48;
         norm  = (sh > NORM_MAX) ? {1'b0, NORM_MAX} : sh[63:0];
         scale = s;
         // fold the scale into every weight
         if (c[63] || s == 0 || s < floor_q) begin
            foreach (weights[i]) begin
               p  = mag(weights[i]) * s;
               sh = p >> 32;
               m  = (sh > DIV_CAP) ? 64'(DIV_CAP) : sh[63:0];
               mw = m;
               weights[i] = clamp32((weights[i][31] ^ c[63]) ? -mw : mw);
            end
            scale = ONE_SCALE;
         end
      endfunction

      // accepted item: update the mirror, queue a result on last
      function void note(logic [1:0] mode, logic [11:0] idx, logic signed [31:0] value,
                         logic signed [31:0] coef, bit last);
         logic signed [63:0] v;
         logic signed [63:0] c;
         logic signed [63:0] cv;
         logic signed [63:0] d;
         logic signed [31:0] w;
         vec_result_type     r;
         v = value;
         c = coef;
         if (mode == MODE_SCALE) begin
            scale_step(c);
         end else if (idx >= DEPTH) begin
            err_seen = 1;
         end else begin
            w = weights[idx];
            case (mode)
               MODE_DOT: begin
                  dot_step(w, v);
               end
               MODE_ADD: begin
                  cv = c * v;
                  d  = div_capped({64'd0, mag(cv)} << 8, scale);
                  norm_sub(square_sat(eff_mag(w)));
                  weights[idx] = clamp32(w + (cv[63] ? -d : d));
                  norm_add(square_sat(eff_mag(weights[idx])));
               end
               default: begin
                  d = div_capped({64'd0, mag(v)} << 32, scale);
                  norm_sub(square_sat(eff_mag(w)));
                  weights[idx] = clamp32(v[63] ? -d : d);
                  norm_add(mag(v) * mag(v));
               end
            endcase
         end
         if (last) begin
            r.dot  = acc;
            r.nrm  = norm[62:0];
            r.ierr = err_seen;
            pending = {pending, r};
            acc      = '0;
            err_seen = 0;
         end
      endfunction

      function void check(logic signed [63:0] dot, logic [62:0] nrm, logic ierr);
         vec_result_type e;
         if (pending.size() == 0) begin
            $error("result with none expected: dot_sum %0d", dot);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (dot !== e.dot) begin
            $error("dot_sum expected %0d actual %0d", e.dot, dot);
            errors++;
         end
         if (nrm !== e.nrm) begin
            $error("squared_norm expected %0d actual %0d", e.nrm, nrm);
            errors++;
         end
         if (ierr !== e.ierr) begin
            $error("index_error expected %0b actual %0b", e.ierr, ierr);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_mode = MODE_DOT;
   logic [11:0]        req_index = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_coef = '0;
   logic               req_last = 0;
   logic               rsp_valid;
   logic signed [63:0] rsp_dot_sum;
   logic [62:0]        rsp_squared_norm;
   logic               rsp_index_error;
   logic               csr_we = 0;
   logic [31:0]        csr_wdata = '0;

   weight_scoreboard sb;
   int idle_cycles = 0;
   int burst_left = 1;

   scaled_dense_weight_vector_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_index(req_index), .req_value(req_value),
      .req_coef(req_coef), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_dot_sum(rsp_dot_sum),
      .rsp_squared_norm(rsp_squared_norm), .rsp_index_error(rsp_index_error),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_dot_sum, rsp_squared_norm, rsp_index_error);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // hold the item until accepted, then update the mirror
   task automatic send(input logic [1:0] m, input logic [11:0] ix, input logic [31:0] vl,
                       input logic [31:0] cf, input bit lt);
      req_mode  <= m;
      req_index <= ix;
      req_value <= vl;
      req_coef  <= cf;
      req_last  <= lt;
      start     <= 1;
      do @(posedge clock); while (busy);
      sb.note(m, ix, vl, cf, lt);
   endtask

   // bursts with random gaps between them
   task automatic pace();
      burst_left--;
      if (burst_left <= 0) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // all results in and block idle
   task automatic wait_idle();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_floor(input logic [31:0] val);
      csr_we    <= 1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
      sb.floor_q = val;
   endtask

   function automatic logic [31:0] near_zero();
      return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
   endfunction

   task automatic random_item();
      logic [1:0]  m;
      logic [11:0] ix;
      logic [31:0] vl;
      logic [31:0] cf;
      int          r;
      r  = $urandom_range(0, 99);
      m  = (r < 36) ? MODE_DOT : (r < 66) ? MODE_ADD : (r < 98) ? MODE_SET : MODE_SCALE;
      ix = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
      vl = $urandom_range(0, 1) ? $urandom : near_zero();
      cf = $urandom_range(0, 1) ? $urandom : near_zero();
      // scale coefficients mostly near one so folds stay rare
      if (m == MODE_SCALE) begin
         case ($urandom_range(0, 5))
            0: cf = $urandom;
            1: cf = -int'($urandom_range(1, 32'h0200_0000));
            default: cf = $urandom_range(32'h00C0_0000, 32'h0140_0000);
         endcase
      end
      send(m, ix, vl, cf, $urandom_range(0, 3) == 0);
      pace();
   endtask

   logic [31:0] floors [5] = '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
                               32'h4000_0000, 32'h0001_0000};

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 0;
      wait_idle();
      for (int ph = 0; ph < 5; ph++) begin
         write_floor(floors[ph]);
         if (ph == 0) begin
            // directed: field extremes, saturation, scale and fold cases
            send(MODE_SET, 12'd0, 32'h7FFF_FFFF, 32'h0, 0);
            send(MODE_SET, 12'd4095, 32'h8000_0000, 32'h0, 0);
            send(MODE_ADD, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
            send(MODE_ADD, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 0);
            send(MODE_DOT, 12'd0, 32'h8000_0000, 32'h0, 0);
            send(MODE_DOT, 12'd4095, 32'h8000_0000, 32'h0, 1);
            send(MODE_SET, 12'd1, 32'h0, 32'h0, 0);
            send(MODE_ADD, 12'd1, 32'h0100_0000, 32'h0100_0000, 0);
            send(MODE_SCALE, 12'd0, 32'h0, 32'h0100_0000, 1);
            send(MODE_SCALE, 12'd0, 32'h0, 32'h0080_0000, 0);
            send(MODE_ADD, 12'd2, 32'hFF00_0000, 32'h0100_0000, 0);
            send(MODE_DOT, 12'd2, 32'h0100_0000, 32'h0, 1);
            send(MODE_SCALE, 12'd0, 32'h0, 32'hFF00_0000, 0);
            send(MODE_DOT, 12'd1, 32'h7FFF_FFFF, 32'h0, 1);
            send(MODE_SCALE, 12'd0, 32'h0, 32'h7FFF_FFFF, 0);
            send(MODE_SCALE, 12'd0, 32'h0, 32'h7FFF_FFFF, 0);
            send(MODE_SCALE, 12'd0, 32'h0, 32'h7FFF_FFFF, 1);
            send(MODE_SET, 12'd3, 32'h0000_0001, 32'h0, 0);
            send(MODE_DOT, 12'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
            send(MODE_SCALE, 12'd0, 32'h0, 32'h0000_0000, 1);
            send(MODE_DOT, 12'd0, 32'h7FFF_FFFF, 32'h0, 1);
         end
         for (int k = 0; k < RANDOM_PER_PHASE; k++) random_item();
         // close the open vector so its result is checked
         send(MODE_DOT, 12'($urandom), $urandom, $urandom, 1);
         wait_idle();
      end
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
